[hdl/s2u_pkg.sv]
// shared types and constants for the shift-jis to utf-8 converter
package s2u_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_BAD_ARG  = 2'd2;
    localparam logic [1:0] ST_TOO_SMALL = 2'd3;

    localparam logic [1:0] HALT_RUN   = 2'd0;
    localparam logic [1:0] HALT_NUL   = 2'd1;
    localparam logic [1:0] HALT_BAD   = 2'd2;
    localparam logic [1:0] HALT_SMALL = 2'd3;

    localparam logic [0:0] CFG_CAPACITY = 1'b0;
    localparam logic [0:0] CFG_ENTRIES  = 1'b1;

    localparam logic [15:0] QMARK      = 16'h003F;
    localparam logic [7:0]  ASCII_MAX  = 8'h7F;
    localparam logic [7:0]  KANA_LO    = 8'hA1;
    localparam logic [7:0]  KANA_HI    = 8'hDF;
    localparam logic [15:0] KANA_BASE  = 16'hFF61;

    // command from front to back
    typedef enum logic [1:0] {
        CMD_EMIT,    // emit code point directly
        CMD_SEARCH,  // look up key, emit result or '?'
        CMD_NONE     // no character, only flags
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] code;      // code point or search key
        logic        nul_end;   // halt by nul after this character
        logic        repl;      // replacement already known
        logic        last;      // status item follows
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_WAIT,
        BK_EMIT,
        BK_STATUS
    } bk_state_t;

endpackage

[hdl/s2u_front.sv]
// front end: accepts items and classifies source bytes
module s2u_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic           mode,
    input  logic [7:0]     source_byte,
    input  logic           last_byte,
    output logic           cmd_valid,
    output s2u_pkg::cmd_t  cmd,
    input  logic           cmd_full
);
    import s2u_pkg::*;

    logic [7:0] lead_reg, lead_next;
    logic       waiting_reg, waiting_next;
    logic       halted_reg, halted_next;

    assign full = cmd_full;

    // classify one convert transaction
    always_comb
    begin
        lead_next    = lead_reg;
        waiting_next = waiting_reg;
        halted_next  = halted_reg;
        cmd_valid    = 1'b0;
        cmd.kind     = CMD_NONE;
        cmd.code     = 16'd0;
        cmd.nul_end  = 1'b0;
        cmd.repl     = 1'b0;
        cmd.last     = last_byte;
        if (push && !cmd_full && mode)
        begin
            if (!halted_reg)
            begin
                if (waiting_reg)
                begin
                    waiting_next = 1'b0;
                    if (source_byte == 8'd0)
                    begin
                        cmd.kind = CMD_EMIT;
                        cmd.code = QMARK;
                        cmd.repl = 1'b1;
                        cmd.nul_end = 1'b1;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        cmd.kind = CMD_SEARCH;
                        cmd.code = {lead_reg, source_byte};
                    end
                end
                else if (source_byte == 8'd0)
                begin
                    cmd.nul_end = 1'b1;
                    halted_next = 1'b1;
                end
                else if (source_byte <= ASCII_MAX)
                begin
                    cmd.kind = CMD_EMIT;
                    cmd.code = {8'd0, source_byte};
                end
                else if (source_byte >= KANA_LO && source_byte <= KANA_HI)
                begin
                    cmd.kind = CMD_EMIT;
                    cmd.code = KANA_BASE + {8'd0, source_byte - KANA_LO};
                end
                else if (last_byte)
                begin
                    cmd.kind = CMD_EMIT;
                    cmd.code = QMARK;
                    cmd.repl = 1'b1;
                end
                else
                begin
                    lead_next = source_byte;
                    waiting_next = 1'b1;
                end
            end
            // every convert transaction reaches the back end so it checks capacity
            cmd_valid = 1'b1;
            if (last_byte)
            begin
                waiting_next = 1'b0;
                halted_next  = 1'b0;
            end
        end
    end

    // string state of the front end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= 8'd0;
            waiting_reg <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            lead_reg    <= lead_next;
            waiting_reg <= waiting_next;
            halted_reg  <= halted_next;
        end
    end
endmodule

[hdl/s2u_cmd_fifo.sv]
// short command queue between front and back
module s2u_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  s2u_pkg::cmd_t  wr_data,
    output logic           fifo_full,
    input  logic           rd_en,
    output s2u_pkg::cmd_t  rd_data,
    output logic           fifo_empty
);
    import s2u_pkg::*;

    cmd_t       slot_reg [2];
    logic [1:0] wp_reg, rp_reg;

    assign fifo_full  = (wp_reg[0] == rp_reg[0]) && (wp_reg[1] != rp_reg[1]);
    assign fifo_empty = (wp_reg == rp_reg);
    assign rd_data    = slot_reg[rp_reg[0]];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en && !fifo_full)
            slot_reg[wp_reg[0]] <= wr_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !fifo_full)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en && !fifo_empty)
                rp_reg <= rp_reg + 2'd1;
        end
    end
endmodule

[hdl/s2u_back.sv]
// back end: table memory, binary search, utf-8 emit and status
module s2u_back #(
    parameter int TABLE_DEPTH = 8192,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tbl_we,
    input  logic [AW-1:0]  tbl_addr,
    input  logic [31:0]    tbl_data,
    input  logic [15:0]    capacity,
    input  logic [AW:0]    entries,
    input  logic           cmd_empty,
    input  s2u_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    output logic           idle,
    output logic           res_valid,
    output logic [7:0]     res_byte,
    output logic           res_data,
    output logic [1:0]     res_status,
    output logic [15:0]    res_count,
    input  logic           res_ready
);
    import s2u_pkg::*;

    logic [31:0] mem [TABLE_DEPTH];
    logic [31:0] rdata_reg;

    bk_state_t   state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic [AW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW:0] mid;
    logic [15:0] cp_reg, cp_next;
    logic [1:0]  nb_reg, nb_next;       // bytes left to send
    logic [1:0]  size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic        repl_reg, repl_next;
    logic [1:0]  halt_reg, halt_next;
    logic        rd_en;
    logic [1:0]  size;
    logic [16:0] need;

    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idle = (state_reg == BK_IDLE);

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            mem[tbl_addr] <= tbl_data;
        if (rd_en)
            rdata_reg <= mem[mid[AW-1:0]];
    end

    always_comb
    begin
        if (cp_reg < 16'h0080)
            size = 2'd1;
        else if (cp_reg < 16'h0800)
            size = 2'd2;
        else
            size = 2'd3;
        need = {1'b0, count_reg} + 17'd1 + {15'd0, size};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        cp_next    = cp_reg;
        nb_next    = nb_reg;
        size_next  = size_reg;
        count_next = count_reg;
        repl_next  = repl_reg;
        halt_next  = halt_reg;
        cmd_pop    = 1'b0;
        rd_en      = 1'b0;
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_data   = 1'b0;
        res_status = ST_OK;
        res_count  = 16'd0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    lo_next  = '0;
                    hi_next  = (entries > (AW+1)'(TABLE_DEPTH)) ?
                               (AW+1)'(TABLE_DEPTH) : entries;
                    cp_next  = cmd.code;
                    if (halt_reg != HALT_RUN)
                        state_next = cmd.last ? BK_STATUS : BK_IDLE;
                    else if (capacity == 16'd0)
                    begin
                        halt_next  = HALT_BAD;
                        state_next = cmd.last ? BK_STATUS : BK_IDLE;
                    end
                    else
                    begin
                        if (cmd.repl)
                            repl_next = 1'b1;
                        case (cmd.kind)
                            CMD_SEARCH: state_next = BK_SEARCH;
                            CMD_EMIT:   state_next = BK_EMIT;
                            default:
                            begin
                                if (cmd.nul_end)
                                    halt_next = HALT_NUL;
                                state_next = cmd.last ? BK_STATUS : BK_IDLE;
                            end
                        endcase
                    end
                end
            end
            BK_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en = 1'b1;
                    state_next = BK_WAIT;
                end
                else
                begin
                    cp_next = QMARK;
                    repl_next = 1'b1;
                    state_next = BK_EMIT;
                end
            end
            BK_WAIT:
            begin
                if (rdata_reg[31:16] == cp_reg)
                begin
                    if (rdata_reg[15:0] == 16'd0)
                    begin
                        cp_next = QMARK;
                        repl_next = 1'b1;
                    end
                    else
                        cp_next = rdata_reg[15:0];
                    state_next = BK_EMIT;
                end
                else
                begin
                    if (rdata_reg[31:16] < cp_reg)
                        lo_next = mid + 1'b1;
                    else
                        hi_next = mid;
                    state_next = BK_SEARCH;
                end
            end
            BK_EMIT:
            begin
                if (nb_reg == 2'd0)
                begin
                    // first entry: room check
                    if (need > {1'b0, capacity})
                    begin
                        halt_next  = HALT_SMALL;
                        state_next = cur_reg.last ? BK_STATUS : BK_IDLE;
                    end
                    else
                    begin
                        nb_next   = size;
                        size_next = size;
                    end
                end
                else
                begin
                    res_valid = 1'b1;
                    res_data  = 1'b1;
                    case ({size_reg, nb_reg})
                        4'b0101: res_byte = cp_reg[7:0];
                        4'b1010: res_byte = {3'b110, cp_reg[10:6]};
                        4'b1001: res_byte = {2'b10, cp_reg[5:0]};
                        4'b1111: res_byte = {4'b1110, cp_reg[15:12]};
                        4'b1110: res_byte = {2'b10, cp_reg[11:6]};
                        default: res_byte = {2'b10, cp_reg[5:0]};
                    endcase
                    if (res_ready)
                    begin
                        nb_next = nb_reg - 2'd1;
                        count_next = count_reg + 16'd1;
                        if (nb_reg == 2'd1)
                        begin
                            if (cur_reg.nul_end)
                                halt_next = HALT_NUL;
                            state_next = cur_reg.last ? BK_STATUS : BK_IDLE;
                        end
                    end
                end
            end
            BK_STATUS:
            begin
                res_valid = 1'b1;
                res_count = count_reg;
                if (halt_reg == HALT_SMALL)
                    res_status = ST_TOO_SMALL;
                else if (halt_reg == HALT_BAD)
                begin
                    res_status = ST_BAD_ARG;
                    res_count  = 16'd0;
                end
                else
                    res_status = repl_reg ? ST_REPLACED : ST_OK;
                if (res_ready)
                begin
                    count_next = 16'd0;
                    repl_next  = 1'b0;
                    halt_next  = HALT_RUN;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            nb_reg    <= 2'd0;
            count_reg <= 16'd0;
            repl_reg  <= 1'b0;
            halt_reg  <= HALT_RUN;
        end
        else
        begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
            count_reg <= count_next;
            repl_reg  <= repl_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        cp_reg   <= cp_next;
        size_reg <= size_next;
    end
endmodule

[hdl/s2u_out_fifo.sv]
// output result queue
module s2u_out_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [27:0] wr_data,
    output logic        ready,
    input  logic        pop,
    output logic [27:0] rd_data,
    output logic        empty
);
    logic [27:0] slot_reg [2];
    logic [1:0]  wp_reg, rp_reg;
    logic        full;

    assign full    = (wp_reg[0] == rp_reg[0]) && (wp_reg[1] != rp_reg[1]);
    assign ready   = !full;
    assign empty   = (wp_reg == rp_reg);
    assign rd_data = slot_reg[rp_reg[0]];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            slot_reg[wp_reg[0]] <= wr_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
                wp_reg <= wp_reg + 2'd1;
            if (pop && !empty)
                rp_reg <= rp_reg + 2'd1;
        end
    end
endmodule

[hdl/sjis_to_utf8_converter.sv]
// top level of the shift-jis to utf-8 converter
//
// Input side is a queue: an item is taken when push is high and full is low.
// Load items (mode 0) write one table entry of key and code point; convert
// items (mode 1) carry one source byte. Results form a queue too: the oldest
// one shows while empty is low and leaves on pop. Each character gives one to
// three utf-8 data bytes; the byte marked last gives a status item afterward.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// must make them only while the block is idle; the block itself does not enforce it.
// Double-byte characters run a binary search over the table, each probe taking
// the search and wait states on the single memory read port, then their bytes
// go out in order while the output queue has room. A two-entry command queue
// splits the classifier from the search and emit sequencer. A load item holds
// full high until the command queue is empty and the sequencer is idle, so
// loads stay in order. When pop is held low the output queue fills and the
// sequencer stops, then full rises. Reset clears all string state and sets
// capacity to 256 and entries to 0; the table is not cleared.
module sjis_to_utf8_converter #(
    parameter int TABLE_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [12:0] table_index,
    input  logic [15:0] table_key,
    input  logic [15:0] table_value,
    input  logic [7:0]  source_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        is_data,
    output logic        end_of_string,
    output logic [1:0]  status,
    output logic [15:0] bytes_written,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import s2u_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0] cap_reg;
    logic [13:0] ent_reg;
    cmd_t        f_cmd, q_cmd;
    logic        f_valid, q_full, q_empty, q_pop;
    logic        bk_idle, in_block;
    logic        r_valid, r_data, r_ready;
    logic [7:0]  r_byte;
    logic [1:0]  r_status;
    logic [15:0] r_count;
    logic [27:0] o_data;
    logic        tbl_we;
    logic [AW:0] entries;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 16'd256;
            ent_reg <= 14'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAPACITY: cap_reg <= cfg_data;
                CFG_ENTRIES:  ent_reg <= cfg_data[13:0];
                default:      ;
            endcase
        end
    end

    // saturate entry count at the table depth
    always_comb
    begin
        if ({18'd0, ent_reg} > TABLE_DEPTH)
            entries = (AW+1)'(TABLE_DEPTH);
        else
            entries = (AW+1)'(ent_reg);
    end

    // a load waits until earlier convert transactions are done with the table
    assign in_block = q_full || (!mode && (!q_empty || !bk_idle));

    // table writes go straight in; index beyond depth is dropped
    assign tbl_we = push && !full && !mode && ({19'd0, table_index} < TABLE_DEPTH);

    s2u_front u_front (
        .clk, .rst_n, .push, .full, .mode, .source_byte, .last_byte,
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_full(in_block)
    );

    s2u_cmd_fifo u_cmdq (
        .clk, .rst_n, .wr_en(f_valid), .wr_data(f_cmd), .fifo_full(q_full),
        .rd_en(q_pop), .rd_data(q_cmd), .fifo_empty(q_empty)
    );

    s2u_back #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_back (
        .clk, .rst_n, .tbl_we,
        .tbl_addr(AW'({3'd0, table_index})),
        .tbl_data({table_key, table_value}),
        .capacity(cap_reg), .entries,
        .cmd_empty(q_empty), .cmd(q_cmd), .cmd_pop(q_pop), .idle(bk_idle),
        .res_valid(r_valid), .res_byte(r_byte), .res_data(r_data),
        .res_status(r_status), .res_count(r_count), .res_ready(r_ready)
    );

    s2u_out_fifo u_outq (
        .clk, .rst_n, .wr_en(r_valid),
        .wr_data({r_byte, r_data, r_status, r_count, 1'b0}),
        .ready(r_ready), .pop, .rd_data(o_data), .empty
    );

    assign out_byte      = o_data[27:20];
    assign is_data       = o_data[19];
    assign end_of_string = !o_data[19];
    assign status        = o_data[18:17];
    assign bytes_written = o_data[16:1];

    // a data transaction never carries status or count
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_data) |-> (status == ST_OK && bytes_written == 16'd0))
        else $error("data item with status fields set");

    // back end never pops an empty command queue
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped while empty");

    // status item leaves string count cleared
    a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid && !r_data && r_ready) |=> (u_back.count_reg == 16'd0))
        else $error("count not cleared after status");
endmodule

[tb/testbench.sv]
// self-checking testbench for the shift-jis to utf-8 converter
module testbench;
    import s2u_pkg::*;

    localparam int DEPTH = 8192;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 80;

    typedef struct {
        logic        mode;
        logic [12:0] index;
        logic [15:0] key;
        logic [15:0] value;
        logic [7:0]  sbyte;
        logic        last;
    } src_item_t;

    typedef struct {
        logic [7:0]  obyte;
        logic        data;
        logic        eos;
        logic [1:0]  st;
        logic [15:0] count;
    } utf8_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        mode = 1'b0;
    logic [12:0] table_index = '0;
    logic [15:0] table_key = '0;
    logic [15:0] table_value = '0;
    logic [7:0]  source_byte = '0;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        end_of_string;
    logic [1:0]  status;
    logic [15:0] bytes_written;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    sjis_to_utf8_converter u_dut (.*);

    always #4 clk = ~clk;

    // converter state mirror
    logic [31:0] code_mem [DEPTH];
    logic [7:0]  lead_byte;
    logic        lead_held;
    int          out_count;
    logic        saw_replace;
    logic [1:0]  halt_code;
    int          capacity = 256;
    int          entries = 0;

    src_item_t   send_q [$];
    src_item_t   cur_item;
    utf8_item_t  utf8_q [$];
    logic [15:0] loaded_keys [$];

    int  cycles = 0;
    int  mismatches = 0;
    int  strings_done = 0;
    int  bytes_seen = 0;
    int  items_sent = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_req = 0;
    bit  calm = 0;

    function automatic logic [15:0] lookup_code(logic [15:0] code);
        int lo, hi, mid;
        lo = 0;
        hi = (entries > DEPTH) ? DEPTH : entries;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (code_mem[mid][31:16] == code) return code_mem[mid][15:0];
            if (code_mem[mid][31:16] < code) lo = mid + 1;
            else hi = mid;
        end
        return 16'h0;
    endfunction

    task automatic add_utf8(logic [7:0] b);
        utf8_item_t r;
        r = '{b, 1'b1, 1'b0, ST_OK, 16'h0};
        utf8_q.push_back(r);
    endtask

    // encode one code point or halt when it does not fit
    task automatic encode_char(logic [15:0] cp);
        int size;
        size = (cp < 16'h80) ? 1 : ((cp < 16'h800) ? 2 : 3);
        if (out_count + 1 + size > capacity) begin
            halt_code = HALT_SMALL;
            return;
        end
        if (size == 1) add_utf8(cp[7:0]);
        else if (size == 2) begin
            add_utf8(8'hC0 | {3'd0, cp[10:6]});
            add_utf8(8'h80 | {2'd0, cp[5:0]});
        end
        else begin
            add_utf8(8'hE0 | {4'd0, cp[15:12]});
            add_utf8(8'h80 | {2'd0, cp[11:6]});
            add_utf8(8'h80 | {2'd0, cp[5:0]});
        end
        out_count += size;
    endtask

    // work out the utf-8 transactions caused by one accepted item
    task automatic convert_item(src_item_t it);
        utf8_item_t r;
        logic [15:0] cp;
        if (!it.mode) begin
            code_mem[it.index] = {it.key, it.value};
            return;
        end
        if (halt_code == HALT_RUN) begin
            if (capacity == 0) halt_code = HALT_BAD;
            else if (lead_held) begin
                lead_held = 1'b0;
                if (it.sbyte == 8'h0) begin
                    saw_replace = 1'b1;
                    encode_char(QMARK);
                    if (halt_code == HALT_RUN) halt_code = HALT_NUL;
                end
                else begin
                    cp = lookup_code({lead_byte, it.sbyte});
                    if (cp == 16'h0) begin
                        cp = QMARK;
                        saw_replace = 1'b1;
                    end
                    encode_char(cp);
                end
                lead_byte = 8'h0;
            end
            else if (it.sbyte == 8'h0) halt_code = HALT_NUL;
            else if (it.sbyte <= ASCII_MAX) encode_char({8'h0, it.sbyte});
            else if (it.sbyte >= KANA_LO && it.sbyte <= KANA_HI)
                encode_char(KANA_BASE + 16'(it.sbyte - KANA_LO));
            else if (it.last) begin
                saw_replace = 1'b1;
                encode_char(QMARK);
            end
            else begin
                lead_byte = it.sbyte;
                lead_held = 1'b1;
            end
        end
        if (it.last) begin
            r = '{8'h0, 1'b0, 1'b1, ST_OK, 16'(out_count)};
            if (halt_code == HALT_SMALL) r.st = ST_TOO_SMALL;
            else if (halt_code == HALT_BAD) begin
                r.st = ST_BAD_ARG;
                r.count = 16'h0;
            end
            else if (saw_replace) r.st = ST_REPLACED;
            utf8_q.push_back(r);
            lead_byte = 8'h0;
            lead_held = 1'b0;
            out_count = 0;
            saw_replace = 1'b0;
            halt_code = HALT_RUN;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) push <= 1'b0;
        else begin
            if (push && !full) begin
                convert_item(cur_item);
                items_sent++;
            end
            if (!push || !full) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    push <= 1'b0;
                end
                else if (send_q.size() > 0) begin
                    cur_item = send_q.pop_front();
                    mode <= cur_item.mode;
                    table_index <= cur_item.index;
                    table_key <= cur_item.key;
                    table_value <= cur_item.value;
                    source_byte <= cur_item.sbyte;
                    last_byte <= cur_item.last;
                    push <= 1'b1;
                    if (!calm && $urandom_range(0, 11) == 0) tx_gap = $urandom_range(1, 19);
                end
                else push <= 1'b0;
            end
        end
    end

    // long hold-off so the block backs up and raises full
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) hold_left <= 0;
        else if (hold_left > 0) hold_left <= hold_left - 1;
        else if (hold_req) begin
            hold_req = 0;
            hold_left <= 500;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        utf8_item_t want;
        if (!rst_n) pop <= 1'b0;
        else begin
            if (pop && !empty) begin
                if (utf8_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction byte=%h", out_byte);
                end
                else begin
                    want = utf8_q.pop_front();
                    if (out_byte !== want.obyte || is_data !== want.data ||
                        end_of_string !== want.eos || status !== want.st ||
                        bytes_written !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h/%b/%b/%0d/%0d got %h/%b/%b/%0d/%0d",
                                     want.obyte, want.data, want.eos, want.st, want.count,
                                     out_byte, is_data, end_of_string, status, bytes_written);
                    end
                    if (want.eos) strings_done++;
                    else bytes_seen++;
                end
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
            end
            else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 19);
            end
        end
    end

    // cycle limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_load(int idx, logic [15:0] k, logic [15:0] v);
        src_item_t it;
        it = '{1'b0, 13'(idx), k, v, 8'($urandom), 1'($urandom)};
        send_q.push_back(it);
    endtask

    task automatic add_byte(logic [7:0] b, logic lst);
        src_item_t it;
        it = '{1'b1, 13'($urandom), 16'($urandom), 16'($urandom), b, lst};
        send_q.push_back(it);
    endtask

    task automatic reg_write(logic idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        if (idx == CFG_CAPACITY) capacity = val & 16'hFFFF;
        else entries = val & 14'h3FFF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (send_q.size() > 0 || push || utf8_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random string of mixed character kinds
    task automatic add_string(int len);
        logic [15:0] k;
        int kind;
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 19) begin
                add_load($urandom_range(64, DEPTH - 1), 16'($urandom), 16'($urandom));
                continue;
            end
            if (kind < 5) add_byte(8'($urandom_range(1, 127)), i == len - 1);
            else if (kind < 7) add_byte(8'($urandom_range(KANA_LO, KANA_HI)), i == len - 1);
            else if (kind < 13 && loaded_keys.size() > 0 && i < len - 1) begin
                k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
                add_byte(k[15:8], 1'b0);
                add_byte(k[7:0], i == len - 1);
            end
            else if (kind < 16) begin
                add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hA0))
                                              : 8'($urandom_range(8'hE0, 8'hFF)), 1'b0);
                add_byte(8'($urandom), i == len - 1);
            end
            else add_byte(8'($urandom), i == len - 1);
        end
    endtask

    initial begin
        logic [15:0] k;
        logic [15:0] v;
        int n;
        lead_byte = 8'h0;
        lead_held = 1'b0;
        out_count = 0;
        saw_replace = 1'b0;
        halt_code = HALT_RUN;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, sorted keys covering 1, 2 and 3 byte encodings
        add_load(0, 16'h8140, 16'h3000);
        add_load(1, 16'h8150, 16'h0041);
        add_load(2, 16'h8160, 16'h00E9);
        add_load(3, 16'h8170, 16'h0000);
        add_load(4, 16'h889F, 16'h4E9C);
        add_load(5, 16'h9FFC, 16'h07FF);
        add_load(6, 16'hE040, 16'h0800);
        add_load(7, 16'hFCFC, 16'hFFFF);
        add_load(8, 16'hFF00, 16'h007F);
        add_load(9, 16'hFFFF, 16'h0080);
        add_load(DEPTH - 1, 16'hFFFF, 16'hFFFF);
        wait_idle();
        reg_write(CFG_ENTRIES, 10);
        reg_write(CFG_CAPACITY, 65535);

        // single bytes, kana bounds, hits, unmapped, miss, lead as last byte
        add_byte(8'h01, 0); add_byte(8'h7F, 0); add_byte(8'hA1, 0); add_byte(8'hDF, 0);
        add_byte(8'h81, 0); add_byte(8'h40, 0);
        add_byte(8'h81, 0); add_byte(8'h60, 0);
        add_byte(8'h81, 0); add_byte(8'h70, 0);
        add_byte(8'hFC, 0); add_byte(8'hFC, 0);
        add_load(12, 16'h1234, 16'h5678);
        add_byte(8'h81, 0); add_byte(8'h41, 0);
        add_byte(8'h80, 1);
        // lead then nul, later bytes ignored
        add_byte(8'h9F, 0); add_byte(8'h00, 0); add_byte(8'h41, 0); add_byte(8'h42, 1);
        // plain nul end
        add_byte(8'h41, 0); add_byte(8'h00, 0); add_byte(8'hE0, 1);
        wait_idle();

        // zero capacity, capacity one
        reg_write(CFG_CAPACITY, 0);
        add_byte(8'h41, 0); add_byte(8'h42, 1);
        wait_idle();
        reg_write(CFG_CAPACITY, 1);
        add_byte(8'h41, 1);
        wait_idle();
        // capacity lowered below the count mid-string
        reg_write(CFG_CAPACITY, 6);
        add_byte(8'h61, 0); add_byte(8'h62, 0); add_byte(8'h63, 0);
        wait_idle();
        reg_write(CFG_CAPACITY, 2);
        add_byte(8'h64, 0); add_byte(8'h65, 1);
        wait_idle();
        // empty search range
        reg_write(CFG_ENTRIES, 0);
        reg_write(CFG_CAPACITY, 16);
        add_byte(8'h88, 0); add_byte(8'h9F, 0); add_byte(8'hB0, 1);
        wait_idle();
        // full table size, no lookups
        reg_write(CFG_ENTRIES, DEPTH);
        add_byte(8'h7A, 0); add_byte(8'hE0, 0); add_byte(8'h00, 1);
        wait_idle();

        // random phase: sorted random tables, then strings
        for (int round = 0; round < 4; round++) begin
            n = $urandom_range(8, 24);
            k = 16'h8040;
            loaded_keys.delete();
            for (int i = 0; i < n; i++) begin
                k += 16'($urandom_range(1, 300));
                if (k >= 16'hA100 && k < 16'hE000) k += 16'h3F00;
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(0, 1) ? 16'h0 : 16'($urandom_range(1, 16'h7F));
                    1: v = 16'($urandom_range(16'h80, 16'h7FF));
                    default: v = 16'($urandom_range(16'h800, 16'hFFFF));
                endcase
                add_load(i, k, v);
                loaded_keys.push_back(k);
            end
            wait_idle();
            reg_write(CFG_ENTRIES, $urandom_range(1, n));
            reg_write(CFG_CAPACITY, (round == 1) ? $urandom_range(4, 12)
                                                 : $urandom_range(20, 300));
            if (round == 3) calm = 1;
            for (int s = 0; s < 4; s++) begin
                add_string($urandom_range(2, 9));
                if (round == 1 && s == 0) hold_req = 1;
            end
            wait_idle();
        end

        if (utf8_q.size() > 0) mismatches += utf8_q.size();
        $display("%0d input items, %0d utf-8 bytes and %0d status transactions checked",
                 items_sent, bytes_seen, strings_done);
        $display("tested capacity extremes, empty and full search range, stall backpressure");
        if (mismatches == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
